FILE: rtl/prp_pkg.sv
// Shared types, widths and constants for the point rotate and project block.
// No dependencies; every other file in rtl/ imports this package.
package prp_pkg;

	// Screen geometry in pixels
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;

	// Field widths
	localparam int COORD_W = 16;
	localparam int TRIG_W  = 16;
	localparam int FOCAL_W = 16;
	localparam int AXIS_W  = 2;
	localparam int SX_W    = 8;
	localparam int SY_W    = 7;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// Focal length (Q8.8) times 16 lines up with coordinates in Q4.12
	localparam int FOCAL_SCALE_SH = 4;

	// Projection arithmetic widths
	localparam int DEN_W   = FOCAL_W + FOCAL_SCALE_SH + 2;
	localparam int NUM_W   = FOCAL_W + COORD_W + 1;
	localparam int M_W     = NUM_W - 1;
	localparam int DIV_D_W = DEN_W - 1 + FOCAL_SCALE_SH;

	// Quotient range that still matters after clipping to the screen
	localparam int HALF_X = SCREEN_WIDTH / 2;
	localparam int HALF_Y = SCREEN_HEIGHT / 2;
	localparam int TOP_X  = SCREEN_WIDTH - HALF_X;
	localparam int TOP_Y  = SCREEN_HEIGHT - HALF_Y;
	localparam int QLIM   = (TOP_X > TOP_Y) ? TOP_X : TOP_Y;
	localparam int QW     = $clog2(QLIM + 1);
	localparam int CMP_W  = (M_W > DIV_D_W + QW) ? M_W : DIV_D_W + QW;
	localparam int PIX_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int PIX_W  = $clog2(PIX_MAX + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic [FOCAL_W-1:0]        focal_t;
	typedef logic [AXIS_W-1:0]         axis_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;

	// Rotation axis codes; the fourth code leaves the point unrotated
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// Register indexes
	localparam reg_idx_t REG_AXIS  = 2'd0;
	localparam reg_idx_t REG_COS   = 2'd1;
	localparam reg_idx_t REG_SIN   = 2'd2;
	localparam reg_idx_t REG_FOCAL = 2'd3;

	// Reset values
	localparam axis_t  AXIS_RESET  = AXIS_X;
	localparam trig_t  COS_RESET   = 16'sd16384;
	localparam trig_t  SIN_RESET   = 16'sd0;
	localparam focal_t FOCAL_RESET = 16'd13747;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// Data that travels alongside the divider
	typedef struct packed {
		point_t rot;
		logic   behind;
		logic   neg_x;
		logic   neg_y;
	} side_t;

	// Saturating quotient of one divider lane
	typedef struct packed {
		logic          ovf;
		logic [QW-1:0] q;
	} quot_t;

	typedef struct packed {
		point_t          rot;
		logic [SX_W-1:0] sx;
		logic [SY_W-1:0] sy;
		logic            behind;
	} result_t;

endpackage

FILE: rtl/prp_rotate.sv
// Rotation front end: two pipeline stages (products, then rounded sums).
// Depends on prp_pkg.
module prp_rotate (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  prp_pkg::point_t point,
	input  prp_pkg::axis_t  axis,
	input  prp_pkg::trig_t  cos_v,
	input  prp_pkg::trig_t  sin_v,
	output logic            valid_s2,
	output prp_pkg::point_t rot_s2
);
	import prp_pkg::*;

	localparam int PROD_W     = COORD_W + TRIG_W;
	localparam int FRAC_SHIFT = 14;
	localparam int RND_W      = PROD_W + 1 - FRAC_SHIFT;

	coord_t a_c, b_c;
	logic signed [PROD_W-1:0] pca_s1, psb_s1, psa_s1, pcb_s1;
	logic   valid_s1;
	axis_t  axis_s1;
	point_t pt_s1;
	coord_t u_c, w_c;
	point_t rot_c;

	// Round half up from Q.26 to Q4.12 and saturate
	function automatic coord_t round_sat(input logic signed [PROD_W:0] sum);
		logic signed [PROD_W:0] biased;
		logic signed [RND_W-1:0] r;
		logic fits;
		biased = sum + ((PROD_W+1)'(1) <<< (FRAC_SHIFT - 1));
		r = biased[PROD_W:FRAC_SHIFT];
		fits = (&r[RND_W-1:COORD_W-1]) || (~|r[RND_W-1:COORD_W-1]);
		if (fits)
			return r[COORD_W-1:0];
		else
			return r[RND_W-1] ? COORD_MIN : COORD_MAX;
	endfunction

	// Pick the two coordinates that turn
	always_comb begin
		unique case (axis)
			AXIS_X: begin
				a_c = point.y;
				b_c = point.z;
			end
			AXIS_Y: begin
				a_c = point.z;
				b_c = point.x;
			end
			default: begin
				a_c = point.x;
				b_c = point.y;
			end
		endcase
	end

	// Stage 1: the four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pca_s1  <= $signed(cos_v) * $signed(a_c);
			psb_s1  <= $signed(sin_v) * $signed(b_c);
			psa_s1  <= $signed(sin_v) * $signed(a_c);
			pcb_s1  <= $signed(cos_v) * $signed(b_c);
			axis_s1 <= axis;
			pt_s1   <= point;
		end
	end

	// Stage 2: sums, rounding and placement back onto the axes
	always_comb begin
		u_c = round_sat((PROD_W+1)'(pca_s1) - (PROD_W+1)'(psb_s1));
		w_c = round_sat((PROD_W+1)'(psa_s1) + (PROD_W+1)'(pcb_s1));
		rot_c = pt_s1;
		unique case (axis_s1)
			AXIS_X: begin
				rot_c.y = u_c;
				rot_c.z = w_c;
			end
			AXIS_Y: begin
				rot_c.z = u_c;
				rot_c.x = w_c;
			end
			AXIS_Z: begin
				rot_c.x = u_c;
				rot_c.y = w_c;
			end
			default: rot_c = pt_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			rot_s2 <= rot_c;
	end

endmodule

FILE: rtl/prp_divide.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
// Depends on prp_pkg. Stage index suffix _sd[k]: k = 0 is the overflow check.
module prp_divide (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [prp_pkg::M_W-1:0]      m_x,
	input  logic [prp_pkg::M_W-1:0]      m_y,
	input  logic [prp_pkg::DIV_D_W-1:0]  d,
	input  prp_pkg::side_t               side,
	output logic                         out_valid,
	output prp_pkg::quot_t               quot_x,
	output prp_pkg::quot_t               quot_y,
	output prp_pkg::side_t               side_out
);
	import prp_pkg::*;

	logic                 valid_sd [0:QW];
	logic [M_W-1:0]       rem_x_sd [0:QW];
	logic [M_W-1:0]       rem_y_sd [0:QW];
	quot_t                qx_sd    [0:QW];
	quot_t                qy_sd    [0:QW];
	side_t                side_sd  [0:QW];
	logic [DIV_D_W-1:0]   d_sd     [0:QW-1];
	logic [CMP_W-1:0]     dtop_c;

	// Flag quotients too large for QW bits; they clip anyway
	assign dtop_c = CMP_W'(d) << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sd[0] <= 1'b0;
		else if (en)
			valid_sd[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_sd[0] <= m_x;
			rem_y_sd[0] <= m_y;
			qx_sd[0]    <= '{ovf: (CMP_W'(m_x) >= dtop_c), q: '0};
			qy_sd[0]    <= '{ovf: (CMP_W'(m_y) >= dtop_c), q: '0};
			side_sd[0]  <= side;
			d_sd[0]     <= d;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int J = QW - k;
		logic [CMP_W-1:0] dsh;
		logic             gx, gy;
		quot_t            qx_n, qy_n;

		always_comb begin
			dsh  = CMP_W'(d_sd[k-1]) << J;
			gx   = CMP_W'(rem_x_sd[k-1]) >= dsh;
			gy   = CMP_W'(rem_y_sd[k-1]) >= dsh;
			qx_n = qx_sd[k-1];
			qy_n = qy_sd[k-1];
			qx_n.q[J] = gx;
			qy_n.q[J] = gy;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_sd[k] <= 1'b0;
			else if (en)
				valid_sd[k] <= valid_sd[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_sd[k] <= gx ? M_W'(CMP_W'(rem_x_sd[k-1]) - dsh) : rem_x_sd[k-1];
				rem_y_sd[k] <= gy ? M_W'(CMP_W'(rem_y_sd[k-1]) - dsh) : rem_y_sd[k-1];
				qx_sd[k]    <= qx_n;
				qy_sd[k]    <= qy_n;
				side_sd[k]  <= side_sd[k-1];
			end
		end

		// Divisor is dropped after the last step
		if (k < QW) begin : g_div
			always_ff @(posedge clk) begin
				if (en)
					d_sd[k] <= d_sd[k-1];
			end
		end
	end

	assign out_valid = valid_sd[QW];
	assign quot_x    = qx_sd[QW];
	assign quot_y    = qy_sd[QW];
	assign side_out  = side_sd[QW];

endmodule

FILE: rtl/prp_project.sv
// Projection back end: denominator and numerators, divider set-up, the divider,
// and the clip to screen. Depends on prp_pkg and prp_divide.
module prp_project (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  prp_pkg::point_t  rot,
	input  prp_pkg::focal_t  focal,
	output logic             valid_sf,
	output prp_pkg::result_t res_sf
);
	import prp_pkg::*;

	logic signed [DEN_W-1:0] den_c;
	logic                    valid_s3, behind_s3;
	logic signed [DEN_W-1:0] den_s3;
	logic signed [NUM_W-1:0] nx_s3, ny_s3;
	point_t                  rot_s3;

	logic [DIV_D_W-1:0] d_c;
	logic               valid_s4;
	logic [M_W-1:0]     mx_s4, my_s4;
	logic [DIV_D_W-1:0] d_s4;
	side_t              side_s4;

	logic            dv_valid;
	quot_t           qx, qy;
	side_t           dv_side;
	logic [PIX_W-1:0] px_c, py_c;
	result_t         res_c;

	// Dividend for a floor division: negative values are biased by d - 1
	function automatic logic [M_W-1:0] dividend(input logic signed [NUM_W-1:0] n,
			input logic [DIV_D_W-1:0] dd);
		if (n[NUM_W-1])
			return M_W'(-n) + M_W'(dd) - M_W'(1);
		else
			return M_W'(n);
	endfunction

	// Centre plus or minus the quotient, held inside the screen
	function automatic logic [PIX_W-1:0] place(input quot_t qt, input logic neg,
			input logic [PIX_W-1:0] half, input logic [PIX_W-1:0] top);
		logic [PIX_W-1:0] lim;
		logic [PIX_W-1:0] qs;
		lim = neg ? half : top;
		if (qt.ovf || PIX_W'(qt.q) > lim)
			qs = lim;
		else
			qs = PIX_W'(qt.q);
		return neg ? half - qs : half + qs;
	endfunction

	// Stage 3: denominator 16f + z and the numerators f * coord
	assign den_c = $signed({{(DEN_W-FOCAL_W-FOCAL_SCALE_SH){1'b0}}, focal,
			{FOCAL_SCALE_SH{1'b0}}}) + DEN_W'($signed(rot.z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3    <= den_c;
			behind_s3 <= den_c[DEN_W-1] || (den_c == '0);
			nx_s3     <= $signed({1'b0, focal}) * $signed(rot.x);
			ny_s3     <= $signed({1'b0, focal}) * $signed(rot.y);
			rot_s3    <= rot;
		end
	end

	// Stage 4: divisor 16 * den and magnitudes for the divider
	assign d_c = {den_s3[DEN_W-2:0], {FOCAL_SCALE_SH{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4   <= dividend(nx_s3, d_c);
			my_s4   <= dividend(ny_s3, d_c);
			d_s4    <= d_c;
			side_s4 <= '{rot: rot_s3, behind: behind_s3,
					neg_x: nx_s3[NUM_W-1], neg_y: ny_s3[NUM_W-1]};
		end
	end

	prp_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.m_x      (mx_s4),
		.m_y      (my_s4),
		.d        (d_s4),
		.side     (side_s4),
		.out_valid(dv_valid),
		.quot_x   (qx),
		.quot_y   (qy),
		.side_out (dv_side)
	);

	// Final stage: clip to the screen, zero the pixels behind the viewer
	always_comb begin
		px_c = place(qx, dv_side.neg_x, PIX_W'(HALF_X), PIX_W'(TOP_X));
		py_c = place(qy, dv_side.neg_y, PIX_W'(HALF_Y), PIX_W'(TOP_Y));
		res_c.rot    = dv_side.rot;
		res_c.behind = dv_side.behind;
		res_c.sx     = dv_side.behind ? '0 : SX_W'(px_c);
		res_c.sy     = dv_side.behind ? '0 : SY_W'(py_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sf <= 1'b0;
		else if (en)
			valid_sf <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_sf <= res_c;
	end

	a_pixel_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid |-> (px_c <= PIX_W'(SCREEN_WIDTH)) && (py_c <= PIX_W'(SCREEN_HEIGHT)))
		else $error("projected pixel lies off the screen");

endmodule

FILE: rtl/prp_outbuf.sv
// Output register with one skid entry; the pipeline advances while the skid is empty.
// Depends on prp_pkg.
module prp_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  prp_pkg::result_t in_res,
	output logic             en,
	output logic             out_valid,
	input  logic             out_ready,
	output prp_pkg::result_t out_res
);
	import prp_pkg::*;

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    take, out_fire;

	assign en       = ~skid_v_q;
	assign take     = in_valid & en;
	assign out_fire = out_v_q & out_ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire)
				skid_v_q <= 1'b0;
		end else if (take) begin
			if (out_v_q && !out_ready)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (out_fire) begin
			out_v_q <= 1'b0;
		end
	end

	// Data: refill from the skid first, else from the pipeline
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire)
				out_q <= skid_q;
		end else if (take) begin
			if (out_v_q && !out_ready)
				skid_q <= in_res;
			else
				out_q <= in_res;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while the output register is empty");

endmodule

FILE: rtl/point_rotate_and_project.sv
// Top level: configuration registers, rotation, projection and output buffer.
// Depends on prp_pkg, prp_rotate, prp_project, prp_outbuf.
//
// Usage
//   Input channel (in_valid/in_ready) carries one point per request in Q4.12.
//   Output channel (out_valid/out_ready) returns one result per point, in order:
//   the rotated point and the clipped pixel column and row, or a behind_viewer
//   flag with both pixels at zero when f + z is not positive.
//   Configuration (cfg_we/cfg_index/cfg_data) writes the axis, cosine, sine and
//   focal length registers; write only while no request is in flight.
// Pipeline
//   From acceptance to out_valid: two rotation stages,
//   two projection set-up stages, QW + 1 divider stages (an overflow check, then
//   one quotient bit each, QW = 7 for a 128 x 64 screen), the clip stage and the output register.
//   Takes one request per cycle while in_ready is high; the divider chain sets the depth.
// Reset
//   arst_n clears all valid flags and loads the register defaults (X axis,
//   cosine 1.0, sine 0, focal length 13747 in Q8.8).
// Back-pressure
//   When out_ready is low the result holds; one more result is caught in a skid
//   entry, after which in_ready drops and the whole pipeline holds.
module point_rotate_and_project (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  prp_pkg::coord_t               point_x,
	input  prp_pkg::coord_t               point_y,
	input  prp_pkg::coord_t               point_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output prp_pkg::coord_t               rotated_x,
	output prp_pkg::coord_t               rotated_y,
	output prp_pkg::coord_t               rotated_z,
	output logic [prp_pkg::SX_W-1:0]      screen_x,
	output logic [prp_pkg::SY_W-1:0]      screen_y,
	output logic                          behind_viewer,
	input  logic                          cfg_we,
	input  prp_pkg::reg_idx_t             cfg_index,
	input  logic [prp_pkg::CFG_W-1:0]     cfg_data
);
	import prp_pkg::*;

	axis_t   axis_q;
	trig_t   cos_q, sin_q;
	focal_t  focal_q;
	logic    en;
	point_t  point_c;
	logic    valid_s2;
	point_t  rot_s2;
	logic    valid_sf;
	result_t res_sf, res_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= AXIS_RESET;
			cos_q   <= COS_RESET;
			sin_q   <= SIN_RESET;
			focal_q <= FOCAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS:  axis_q  <= cfg_data[AXIS_W-1:0];
				REG_COS:   cos_q   <= $signed(cfg_data[TRIG_W-1:0]);
				REG_SIN:   sin_q   <= $signed(cfg_data[TRIG_W-1:0]);
				REG_FOCAL: focal_q <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign point_c  = '{x: point_x, y: point_y, z: point_z};
	assign in_ready = en;

	prp_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.point   (point_c),
		.axis    (axis_q),
		.cos_v   (cos_q),
		.sin_v   (sin_q),
		.valid_s2(valid_s2),
		.rot_s2  (rot_s2)
	);

	prp_project u_project (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(valid_s2),
		.rot     (rot_s2),
		.focal   (focal_q),
		.valid_sf(valid_sf),
		.res_sf  (res_sf)
	);

	prp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_sf),
		.in_res   (res_sf),
		.en       (en),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (res_out)
	);

	assign rotated_x     = res_out.rot.x;
	assign rotated_y     = res_out.rot.y;
	assign rotated_z     = res_out.rot.z;
	assign screen_x      = res_out.sx;
	assign screen_y      = res_out.sy;
	assign behind_viewer = res_out.behind;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input held off with no result waiting");

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind_viewer |-> (screen_x == '0) && (screen_y == '0))
		else $error("point behind viewer reported with a pixel position");

endmodule

FILE: tb/tb_point_rotate_and_project.sv
// Self-checking testbench for point_rotate_and_project: directed table, then random phases.
// Depends on prp_pkg and the RTL top level; a local predictor covers results the table does not give.
`timescale 1ns / 1ps

module tb_point_rotate_and_project;
	import prp_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 400;
	localparam int HOLD_OFF_LEN   = 80;
	localparam int DRAIN_CYCLES   = 30;
	localparam int TIMEOUT_CYCLES = 300000;

	// Fourth axis code: no rotation at all
	localparam axis_t AXIS_NONE = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [CFG_W-1:0]  data;
		point_t            pt;
		bit                typed;
		result_t           want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	coord_t              point_x;
	coord_t              point_y;
	coord_t              point_z;
	logic                out_valid;
	logic                out_ready;
	coord_t              rotated_x;
	coord_t              rotated_y;
	coord_t              rotated_z;
	logic [SX_W-1:0]     screen_x;
	logic [SY_W-1:0]     screen_y;
	logic                behind_viewer;
	logic                cfg_we;
	reg_idx_t            cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// Register copy used for prediction
	axis_t  axis_q  = AXIS_RESET;
	trig_t  cos_q   = COS_RESET;
	trig_t  sin_q   = SIN_RESET;
	focal_t focal_q = FOCAL_RESET;

	result_t   pending_q[$];
	stim_row_t directed_q[$];

	int  error_cnt       = 0;
	int  requests_sent   = 0;
	int  results_checked = 0;
	int  behind_seen     = 0;
	int  settings_used   = 0;
	int  burst_left      = 0;
	bit  hold_req        = 1'b0;
	bit  hold_done       = 1'b0;

	point_rotate_and_project i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rotated_x     (rotated_x),
		.rotated_y     (rotated_y),
		.rotated_z     (rotated_z),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.behind_viewer (behind_viewer),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Round a Q.26 sum to Q4.12, half up, and saturate
	function automatic longint round_q12(longint sum);
		longint r;
		r = (sum + 64'sd8192) >>> 14;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// Floor of centre + f*coord/(16*den), clamped to the screen
	function automatic longint pixel_of(longint coord, longint f, longint den, longint size);
		longint d16, t, p;
		d16 = den * 16;
		t = (size / 2) * d16 + f * coord;
		p = t / d16;
		if ((t % d16) != 0 && t < 0)
			p = p - 1;
		if (p < 0)
			p = 0;
		if (p > size)
			p = size;
		return p;
	endfunction

	// Rotate about the programmed axis, then project onto the screen
	function automatic result_t project_point(point_t pt);
		longint  c, s, f, x, y, z, rx, ry, rz, den, px, py;
		result_t r;
		c = longint'(cos_q);
		s = longint'(sin_q);
		f = longint'(focal_q);
		x = longint'(pt.x);
		y = longint'(pt.y);
		z = longint'(pt.z);
		rx = x;
		ry = y;
		rz = z;
		case (axis_q)
			AXIS_X: begin
				ry = round_q12(c * y - s * z);
				rz = round_q12(s * y + c * z);
			end
			AXIS_Y: begin
				rx = round_q12(c * x + s * z);
				rz = round_q12(c * z - s * x);
			end
			AXIS_Z: begin
				rx = round_q12(c * x - s * y);
				ry = round_q12(s * x + c * y);
			end
			default: ;
		endcase
		den = f * 16 + rz;
		r.rot.x = rx[COORD_W-1:0];
		r.rot.y = ry[COORD_W-1:0];
		r.rot.z = rz[COORD_W-1:0];
		if (den <= 0) begin
			r.sx = '0;
			r.sy = '0;
			r.behind = 1'b1;
		end else begin
			px = pixel_of(rx, f, den, SCREEN_WIDTH);
			py = pixel_of(ry, f, den, SCREEN_HEIGHT);
			r.sx = px[SX_W-1:0];
			r.sy = py[SY_W-1:0];
			r.behind = 1'b0;
		end
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_cnt++;
	endtask

	task automatic compare_field(string name, longint got, longint want);
		if (got != want)
			report_error($sformatf("result %0d %s got %0d expected %0d",
				results_checked, name, got, want));
	endtask

	// Table builders for the directed part
	task automatic row_cfg(reg_idx_t idx, logic [CFG_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = data;
		row.pt = '0;
		row.typed = 1'b0;
		row.want = '0;
		directed_q.push_back(row);
	endtask

	task automatic row_pt(coord_t x, coord_t y, coord_t z);
		stim_row_t row;
		row.kind = ROW_POINT;
		row.idx = REG_AXIS;
		row.data = '0;
		row.pt = '{x: x, y: y, z: z};
		row.typed = 1'b0;
		row.want = '0;
		directed_q.push_back(row);
	endtask

	task automatic row_pt_exp(coord_t x, coord_t y, coord_t z, coord_t rx, coord_t ry,
			coord_t rz, logic [SX_W-1:0] sx, logic [SY_W-1:0] sy, logic b);
		stim_row_t row;
		row.kind = ROW_POINT;
		row.idx = REG_AXIS;
		row.data = '0;
		row.pt = '{x: x, y: y, z: z};
		row.typed = 1'b1;
		row.want.rot = '{x: rx, y: ry, z: rz};
		row.want.sx = sx;
		row.want.sy = sy;
		row.want.behind = b;
		directed_q.push_back(row);
	endtask

	// Offer one request in bursts with random gaps; queue its expected result on acceptance
	task automatic send_point(point_t pt, bit typed, result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		point_x <= pt.x;
		point_y <= pt.y;
		point_z <= pt.z;
		do
			@(posedge clk);
		while (!in_ready);
		pending_q.push_back(typed ? want : project_point(pt));
		requests_sent++;
	endtask

	// Drain the pipeline, then write one register
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AXIS:  axis_q = data[AXIS_W-1:0];
			REG_COS:   cos_q = data;
			REG_SIN:   sin_q = data;
			REG_FOCAL: focal_q = data;
			default: ;
		endcase
	endtask

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return coord_t'(0);
					default: return coord_t'(-1);
				endcase
			end
			default: return coord_t'(int'($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	function automatic trig_t pick_trig();
		case ($urandom_range(0, 7))
			0: return trig_t'(16384);
			1: return trig_t'(-16384);
			2: return trig_t'(0);
			3: return trig_t'($urandom);
			default: return trig_t'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic focal_t pick_focal();
		case ($urandom_range(0, 7))
			0, 1: return focal_t'($urandom_range(0, 2047));
			2: begin
				case ($urandom_range(0, 2))
					0: return focal_t'(0);
					1: return focal_t'(1);
					default: return focal_t'(16'hFFFF);
				endcase
			end
			3: return focal_t'($urandom);
			default: return focal_t'($urandom_range(8000, 20000));
		endcase
	endfunction

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report_error("result with no request waiting");
			end else begin
				want = pending_q.pop_front();
				compare_field("rotated_x", rotated_x, want.rot.x);
				compare_field("rotated_y", rotated_y, want.rot.y);
				compare_field("rotated_z", rotated_z, want.rot.z);
				compare_field("screen_x", screen_x, want.sx);
				compare_field("screen_y", screen_y, want.sy);
				compare_field("behind_viewer", behind_viewer, want.behind);
			end
			results_checked++;
			if (behind_viewer)
				behind_seen++;
		end
	end

	// Receiver: switch between stall patterns, and hold off once for a long stretch
	initial begin : receiver
		int mode;
		int mode_left;
		int cyc;
		mode = 0;
		mode_left = 0;
		cyc = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (cyc % 8) < 5;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Give up after a generous fixed time
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d results outstanding", pending_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int random_sent;
		int phase_len;
		point_t pt;
		random_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_AXIS;
		cfg_data <= '0;

		// Reset values first: origin lands on the screen centre
		row_pt_exp(0, 0, 0, 0, 0, 0, 8'd64, 7'd32, 1'b0);
		row_pt(COORD_MAX, COORD_MAX, COORD_MAX);
		row_pt(COORD_MIN, COORD_MIN, COORD_MIN);
		row_pt(COORD_MAX, COORD_MIN, 0);
		// Quarter turn about Y
		row_cfg(REG_AXIS, CFG_W'(AXIS_Y));
		row_cfg(REG_COS, 16'd0);
		row_cfg(REG_SIN, 16'd16384);
		row_pt(4096, 0, 0);
		row_pt(COORD_MIN, COORD_MAX, COORD_MIN);
		// Cosine and sine both at one about Z: sums saturate
		row_cfg(REG_AXIS, CFG_W'(AXIS_Z));
		row_cfg(REG_COS, 16'd16384);
		row_cfg(REG_SIN, 16'd16384);
		row_pt(COORD_MAX, COORD_MAX, 0);
		row_pt(COORD_MIN, COORD_MAX, COORD_MAX);
		row_pt(COORD_MIN, COORD_MIN, -1);
		// Out of range cosine and sine about X
		row_cfg(REG_AXIS, CFG_W'(AXIS_X));
		row_cfg(REG_COS, 16'h8000);
		row_cfg(REG_SIN, 16'h7FFF);
		row_pt(0, COORD_MAX, COORD_MIN);
		row_pt(-1, COORD_MIN, COORD_MAX);
		// Unused axis code passes the point through
		row_cfg(REG_AXIS, CFG_W'(AXIS_NONE));
		row_pt(1234, -5678, 100);
		// Zero focal length: centre when in front, flagged otherwise
		row_cfg(REG_FOCAL, 16'd0);
		row_pt_exp(100, 200, 0, 100, 200, 0, 8'd0, 7'd0, 1'b1);
		row_pt_exp(100, 200, 50, 100, 200, 50, 8'd64, 7'd32, 1'b0);
		row_pt_exp(-100, -200, -1, -100, -200, -1, 8'd0, 7'd0, 1'b1);
		// Smallest focal length: denominator exactly zero, then one
		row_cfg(REG_FOCAL, 16'd1);
		row_pt_exp(COORD_MAX, COORD_MAX, -16, COORD_MAX, COORD_MAX, -16, 8'd0, 7'd0, 1'b1);
		row_pt(COORD_MAX, COORD_MIN, -15);
		// Largest focal length
		row_cfg(REG_FOCAL, 16'hFFFF);
		row_pt(COORD_MAX, COORD_MAX, COORD_MAX);
		row_pt(COORD_MIN, COORD_MIN, COORD_MIN);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_q[i]) begin
			if (directed_q[i].kind == ROW_WRITE)
				write_reg(directed_q[i].idx, directed_q[i].data);
			else
				send_point(directed_q[i].pt, directed_q[i].typed, directed_q[i].want);
		end
		settings_used = 8;

		// Random phases, each under a fresh register setting
		while (random_sent < RANDOM_ITEMS) begin
			write_reg(REG_AXIS, CFG_W'($urandom_range(0, 3)));
			write_reg(REG_COS, pick_trig());
			write_reg(REG_SIN, pick_trig());
			write_reg(REG_FOCAL, pick_focal());
			settings_used++;
			if (!hold_req && random_sent >= 150) begin
				phase_len = 120;
				hold_req = 1'b1;
			end else begin
				phase_len = $urandom_range(15, 60);
			end
			repeat (phase_len) begin
				pt.x = pick_coord();
				pt.y = pick_coord();
				pt.z = pick_coord();
				send_point(pt, 1'b0, '0);
				random_sent++;
			end
		end

		// Let the last results come out, then watch for strays
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d points under %0d register settings, %0d from the directed table.",
			requests_sent, settings_used, requests_sent - random_sent);
		$display("Checked %0d results, %0d of them behind the viewer; %0d mismatches.",
			results_checked, behind_seen, error_cnt);
		if (error_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/prp_pkg.sv
rtl/prp_rotate.sv
rtl/prp_divide.sv
rtl/prp_project.sv
rtl/prp_outbuf.sv
rtl/point_rotate_and_project.sv
tb/tb_point_rotate_and_project.sv
